// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg: scheduler types and constants
// Shared widths, request codes and status codes for the task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;
  localparam int unsigned NumTaskSlots = 16;
  localparam int unsigned NumLevels    = 8;
  localparam int unsigned TaskW        = $clog2(NumTaskSlots);
  localparam int unsigned LevelW       = $clog2(NumLevels);

  localparam logic [2:0] REQ_ADD_READY   = 3'd0;
  localparam logic [2:0] REQ_ADD_BLOCKED = 3'd1;
  localparam logic [2:0] REQ_REM_READY   = 3'd2;
  localparam logic [2:0] REQ_REM_BLOCKED = 3'd3;
  localparam logic [2:0] REQ_TICK        = 3'd4;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] task_index;
    logic [2:0] task_level;
    logic [1:0] new_status;
  } req_t;

  typedef struct packed {
    logic [3:0] running_task;
    logic [2:0] running_level;
    logic       found;
    logic       switched;
  } rsp_t;
endpackage

// ===== rtl/pts_if.sv =====
// ----------------------------------------------------------------------------
// pts_req_if / pts_rsp_if / pts_cfg_if: valid-ready channels
// Request, response and configuration channels of the scheduler.
// ----------------------------------------------------------------------------
interface pts_req_if import pts_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pts_rsp_if import pts_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pts_cfg_if ();
  logic       valid;
  logic       ready;
  logic [2:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler: fixed-priority scheduler, a ready and a blocked fifo per level
// Ready and blocked fifos share a link table; a sequencer walks queues.
// ----------------------------------------------------------------------------
// add: straight to the response; remove: a walk of its queue, at most one step per
// task slot; tick: a scan of the levels from 0, then the response fields are held
// in state registers until taken. One request at a time: the next one is accepted
// the cycle after the response is taken.
// reset: all queues empty, all tasks ready, idle task current, idle level 7.
module priority_task_scheduler
  import pts_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  pts_req_if.sink   req_i,
  pts_rsp_if.source rsp_o,
  pts_cfg_if.sink   cfg_i
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_TEND  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [TaskW-1:0]  link_q [NumTaskSlots];
  logic [1:0]        stat_q [NumTaskSlots];
  logic [LevelW-1:0] lvl_q  [NumTaskSlots];
  logic [TaskW-1:0]  rhead_q [NumLevels];
  logic [TaskW-1:0]  rtail_q [NumLevels];
  logic [TaskW-1:0]  bhead_q [NumLevels];
  logic [TaskW-1:0]  btail_q [NumLevels];
  logic [NumLevels-1:0] rvalid_q, bvalid_q;
  logic [TaskW-1:0]  cur_q, old_q, pos_q, prev_q;
  logic [2:0]        idle_lvl_q;
  logic              first_q, blk_q, done_q, found_q;
  logic [LevelW-1:0] lv_q, limit_q;
  logic [TaskW-1:0]  cnt_q;
  req_t              req_q;
  rsp_t              rsp;

  function automatic logic [LevelW-1:0] level_of(input logic [TaskW-1:0] t,
                                                 input logic [LevelW-1:0] lt,
                                                 input logic [2:0] ip);
    logic [LevelW-1:0] r;
    r = (t == '0) ? ip[LevelW-1:0] : lt;
    return r;
  endfunction

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = (state_q == S_RESP);
  assign rsp_o.data  = rsp;

  logic [LevelW-1:0] add_lv, req_lv, cur_lv, scan_lv;
  assign add_lv  = (req_i.data.task_index == '0) ? idle_lvl_q[LevelW-1:0]
                                                  : req_i.data.task_level;
  assign req_lv  = level_of(req_q.task_index, lvl_q[req_q.task_index], idle_lvl_q);
  assign cur_lv  = level_of(cur_q, lvl_q[cur_q], idle_lvl_q);
  assign scan_lv = level_of(rhead_q[lv_q], lvl_q[rhead_q[lv_q]], idle_lvl_q);

  logic rem_blk;
  assign rem_blk = (req_q.req_type == REQ_REM_BLOCKED);
  logic [TaskW-1:0] qhead, qtail;
  logic             qvalid;
  assign qhead  = rem_blk ? bhead_q[req_lv] : rhead_q[req_lv];
  assign qtail  = rem_blk ? btail_q[req_lv] : rtail_q[req_lv];
  assign qvalid = rem_blk ? bvalid_q[req_lv] : rvalid_q[req_lv];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (req_i.valid) state_d = S_DEC;
      S_DEC: begin
        case (req_q.req_type)
          REQ_REM_READY, REQ_REM_BLOCKED: state_d = qvalid ? S_WALK : S_RESP;
          REQ_TICK: state_d = S_SCAN;
          default: state_d = S_RESP;
        endcase
      end
      S_WALK: if (pos_q == req_q.task_index || pos_q == qtail
                  || cnt_q == TaskW'(NumTaskSlots - 1)) state_d = S_RESP;
      S_SCAN: begin
        if (lv_q == limit_q || (rvalid_q[lv_q] && scan_lv <= cur_lv
            && 1'b1)) state_d = S_SCAN;
        if (lv_q == limit_q) state_d = S_TEND;
        if (rvalid_q[lv_q] && (scan_lv <= cur_lv || stat_q[cur_q] == ST_BLOCKED)
            && stat_q[rhead_q[lv_q]] == ST_READY && rhead_q[lv_q] != '0)
          state_d = S_TEND;
      end
      S_TEND: state_d = S_RESP;
      S_RESP: if (rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rvalid_q   <= '0;
      bvalid_q   <= '0;
      cur_q      <= '0;
      idle_lvl_q <= 3'd7;
      for (int i = 0; i < NumTaskSlots; i++) stat_q[i] <= ST_READY;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) idle_lvl_q <= cfg_i.data;
      case (state_q)
        S_IDLE: if (req_i.valid) begin
          req_q   <= req_i.data;
          found_q <= 1'b0;
          done_q  <= 1'b0;
          blk_q   <= 1'b1;
          old_q   <= cur_q;
          cnt_q   <= '0;
          first_q <= 1'b1;
          lv_q    <= '0;
          limit_q <= LevelW'(NumLevels - 1);
          if (req_i.data.req_type == REQ_ADD_READY
              || req_i.data.req_type == REQ_ADD_BLOCKED) begin
            if (req_i.data.task_index != '0)
              lvl_q[req_i.data.task_index] <= req_i.data.task_level;
            if (req_i.data.req_type == REQ_ADD_READY) begin
              stat_q[req_i.data.task_index] <= ST_READY;
              if (!rvalid_q[add_lv]) rhead_q[add_lv] <= req_i.data.task_index;
              else link_q[rtail_q[add_lv]] <= req_i.data.task_index;
              rtail_q[add_lv]  <= req_i.data.task_index;
              rvalid_q[add_lv] <= 1'b1;
            end else begin
              stat_q[req_i.data.task_index] <= ST_BLOCKED;
              if (!bvalid_q[add_lv]) bhead_q[add_lv] <= req_i.data.task_index;
              else link_q[btail_q[add_lv]] <= req_i.data.task_index;
              btail_q[add_lv]  <= req_i.data.task_index;
              bvalid_q[add_lv] <= 1'b1;
            end
          end
        end
        S_DEC: begin
          pos_q <= qhead;
          if (req_q.req_type == REQ_TICK) begin
            if (stat_q[cur_q] == ST_RUNNING && cur_q != '0) begin
              limit_q <= cur_lv;
              stat_q[cur_q] <= ST_READY;
              if (!rvalid_q[cur_lv]) rhead_q[cur_lv] <= cur_q;
              else link_q[rtail_q[cur_lv]] <= cur_q;
              rtail_q[cur_lv]  <= cur_q;
              rvalid_q[cur_lv] <= 1'b1;
            end else if (cur_q == '0) begin
              stat_q[0] <= ST_READY;
            end
          end
        end
        S_WALK: begin
          cnt_q   <= cnt_q + 1'b1;
          prev_q  <= pos_q;
          first_q <= 1'b0;
          pos_q   <= link_q[pos_q];
          if (pos_q == req_q.task_index) begin
            found_q <= 1'b1;
            stat_q[req_q.task_index] <= req_q.new_status;
            if (first_q) begin
              if (pos_q == qtail) begin
                if (rem_blk) bvalid_q[req_lv] <= 1'b0;
                else rvalid_q[req_lv] <= 1'b0;
              end else if (rem_blk) bhead_q[req_lv] <= link_q[pos_q];
              else rhead_q[req_lv] <= link_q[pos_q];
            end else if (pos_q == qtail) begin
              if (rem_blk) btail_q[req_lv] <= prev_q;
              else rtail_q[req_lv] <= prev_q;
            end else begin
              link_q[prev_q] <= link_q[pos_q];
            end
          end
        end
        S_SCAN: begin
          lv_q <= lv_q + 1'b1;
          if (rvalid_q[lv_q] && (scan_lv <= cur_lv || stat_q[cur_q] == ST_BLOCKED)) begin
            if (rhead_q[lv_q] == rtail_q[lv_q]) rvalid_q[lv_q] <= 1'b0;
            else rhead_q[lv_q] <= link_q[rhead_q[lv_q]];
            cur_q <= rhead_q[lv_q];
            blk_q <= (stat_q[rhead_q[lv_q]] == ST_BLOCKED);
            if (stat_q[rhead_q[lv_q]] == ST_READY && rhead_q[lv_q] != '0) begin
              stat_q[rhead_q[lv_q]] <= ST_RUNNING;
              done_q <= 1'b1;
            end
          end
        end
        S_TEND: begin
          if (!done_q && blk_q) begin
            cur_q     <= '0;
            stat_q[0] <= ST_RUNNING;
          end
        end
        default: ;
      endcase
    end
  end

  // all state but the idle level, which cfg writes can change, is settled and held while the response waits
  always_comb begin
    rsp.running_task  = cur_q;
    rsp.running_level = cur_lv;
    rsp.found         = found_q;
    rsp.switched      = (req_q.req_type == REQ_TICK) && (cur_q != old_q);
  end
endmodule

// ===== verif/priority_task_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler_tb: self-checking bench for the task scheduler
// A queue-fed driver sends add, remove and tick requests with random gaps,
// while a shadow scheduler predicts each response. A monitor with random
// back-pressure compares each response field by field. The idle level is
// changed between phases while the scheduler has nothing in flight.
// ----------------------------------------------------------------------------
module priority_task_scheduler_tb;
  import pts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCycles = 1500000;
  localparam logic [4:0]  EmptyMark = 5'd16;
  localparam int unsigned SetReady  = 0;
  localparam int unsigned SetBlock  = 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pts_req_if req ();
  pts_rsp_if rsp ();
  pts_cfg_if cfg ();

  priority_task_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req.sink),
    .rsp_o  (rsp.source),
    .cfg_i  (cfg.sink)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow scheduler state
  logic [3:0] sh_link [16];
  logic [1:0] sh_status [16];
  logic [2:0] sh_level [16];
  logic [4:0] sh_head [2][8];
  logic [3:0] sh_tail [2][8];
  logic [3:0] sh_current;
  logic [2:0] sh_idle_level;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   mismatches = 0;
  int   cycle_count = 0;
  bit   calm = 1'b0;
  int   req_gap = 0;
  int   rsp_stall = 0;
  bit   level_known [16];

  function automatic logic [2:0] level_of(logic [3:0] t);
    return (t == 0) ? sh_idle_level : sh_level[t];
  endfunction

  function automatic void fifo_append(int s, int lv, logic [3:0] t);
    if (sh_head[s][lv] >= EmptyMark) sh_head[s][lv] = {1'b0, t};
    else sh_link[sh_tail[s][lv]] = t;
    sh_tail[s][lv] = t;
  endfunction

  function automatic logic [3:0] fifo_pop(int s, int lv);
    logic [3:0] t;
    t = sh_head[s][lv][3:0];
    if (t == sh_tail[s][lv]) sh_head[s][lv] = EmptyMark;
    else sh_head[s][lv] = {1'b0, sh_link[t]};
    return t;
  endfunction

  function automatic bit fifo_unlink(int s, int lv, logic [3:0] t);
    logic [3:0] pos;
    logic [3:0] prev;
    bit first;
    prev = '0;
    first = 1'b1;
    if (sh_head[s][lv] >= EmptyMark) return 1'b0;
    pos = sh_head[s][lv][3:0];
    for (int k = 0; k < 16; k++) begin
      if (pos == t) begin
        if (first) void'(fifo_pop(s, lv));
        else if (pos == sh_tail[s][lv]) sh_tail[s][lv] = prev;
        else sh_link[prev] = sh_link[pos];
        return 1'b1;
      end
      if (pos == sh_tail[s][lv]) return 1'b0;
      prev = pos;
      first = 1'b0;
      pos = sh_link[pos];
    end
    return 1'b0;
  endfunction

  function automatic bit schedule_tick();
    logic [3:0] cur;
    logic [3:0] old;
    logic [3:0] t;
    logic [1:0] st;
    int limit;
    bit done;
    cur = sh_current;
    old = sh_current;
    limit = 7;
    st = ST_BLOCKED;
    done = 1'b0;
    if (sh_status[cur] == ST_RUNNING && cur != 0) begin
      limit = int'(level_of(cur));
      sh_status[cur] = ST_READY;
      fifo_append(SetReady, limit, cur);
    end else if (cur == 0) begin
      sh_status[0] = ST_READY;
    end
    for (int i = 0; i <= limit && !done; i++) begin
      if (sh_head[SetReady][i] < EmptyMark) begin
        t = sh_head[SetReady][i][3:0];
        if (level_of(t) <= level_of(cur) || sh_status[cur] == ST_BLOCKED) begin
          void'(fifo_pop(SetReady, i));
          cur = t;
          st = sh_status[t];
          if (st == ST_READY && t != 0) begin
            sh_status[t] = ST_RUNNING;
            done = 1'b1;
          end
        end
      end
    end
    if (!done && st == ST_BLOCKED) begin
      cur = 0;
      sh_status[0] = ST_RUNNING;
    end
    sh_current = cur;
    return cur != old;
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t o;
    int s;
    o = '0;
    if (r.req_type == REQ_TICK) begin
      o.switched = schedule_tick();
    end else if (r.req_type == REQ_ADD_READY || r.req_type == REQ_ADD_BLOCKED) begin
      s = (r.req_type == REQ_ADD_READY) ? SetReady : SetBlock;
      if (r.task_index != 0) sh_level[r.task_index] = r.task_level;
      sh_status[r.task_index] = (s == SetReady) ? ST_READY : ST_BLOCKED;
      fifo_append(s, level_of(r.task_index), r.task_index);
    end else if (r.req_type == REQ_REM_READY || r.req_type == REQ_REM_BLOCKED) begin
      s = (r.req_type == REQ_REM_READY) ? SetReady : SetBlock;
      o.found = fifo_unlink(s, level_of(r.task_index), r.task_index);
      if (o.found) sh_status[r.task_index] = r.new_status;
    end
    o.running_task = sh_current;
    o.running_level = level_of(sh_current);
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t make_req(logic [2:0] rt, logic [3:0] t, logic [2:0] lv,
                                    logic [1:0] ns);
    req_t r;
    r.req_type = rt;
    r.task_index = t;
    r.task_level = lv;
    r.new_status = ns;
    if ((rt == REQ_ADD_READY || rt == REQ_ADD_BLOCKED) && t != 0) level_known[t] = 1'b1;
    return r;
  endfunction

  // mostly adds and ticks so queues fill up, removals aimed at known tasks
  function automatic req_t random_req();
    int w;
    logic [3:0] t;
    logic [2:0] rt;
    w = $urandom_range(0, 99);
    t = 4'($urandom_range(0, 15));
    if (w < 30) rt = REQ_ADD_READY;
    else if (w < 40) rt = REQ_ADD_BLOCKED;
    else if (w < 55) rt = REQ_REM_READY;
    else if (w < 65) rt = REQ_REM_BLOCKED;
    else if (w < 97) rt = REQ_TICK;
    else rt = 3'($urandom_range(int'(REQ_TICK) + 1, 7));
    if ((rt == REQ_REM_READY || rt == REQ_REM_BLOCKED) && !level_known[t]) t = 0;
    return make_req(rt, t, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready) expected_rsps.push_back(predict_response(req.data));
      if (!req.valid || req.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req.data <= pending_reqs.pop_front();
          req.valid <= 1'b1;
          req_gap = pick_gap();
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", rsp.data);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp.data.running_task !== exp_rsp.running_task ||
              rsp.data.running_level !== exp_rsp.running_level ||
              rsp.data.found !== exp_rsp.found ||
              rsp.data.switched !== exp_rsp.switched) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch: expected %p, got %p", exp_rsp, rsp.data);
          end
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) rsp_stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_idle_level(logic [2:0] v);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk_i); while (!cfg.ready);
    sh_idle_level = v;
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0] phase_levels [5];
    phase_levels = '{3'd7, 3'd0, 3'd5, 3'd7, 3'd2};
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    for (int i = 0; i < 16; i++) begin
      sh_link[i] = '0;
      sh_status[i] = ST_READY;
      sh_level[i] = '0;
      level_known[i] = (i == 0);
    end
    for (int s = 0; s < 2; s++)
      for (int l = 0; l < 8; l++) begin
        sh_head[s][l] = EmptyMark;
        sh_tail[s][l] = '0;
      end
    sh_current = '0;
    sh_idle_level = 3'd7;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty tick, extremes, head, middle and tail removal, idle add
    pending_reqs.push_back(make_req(REQ_TICK, 4'd0, 3'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_ADD_READY, 4'd15, 3'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_ADD_READY, 4'd1, 3'd7, 2'd0));
    pending_reqs.push_back(make_req(REQ_TICK, 4'd0, 3'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_TICK, 4'd0, 3'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_ADD_BLOCKED, 4'd2, 3'd3, 2'd0));
    pending_reqs.push_back(make_req(REQ_REM_BLOCKED, 4'd2, 3'd0, 2'd3));
    pending_reqs.push_back(make_req(REQ_REM_READY, 4'd2, 3'd0, 2'd1));
    pending_reqs.push_back(make_req(REQ_ADD_READY, 4'd3, 3'd2, 2'd0));
    pending_reqs.push_back(make_req(REQ_ADD_READY, 4'd4, 3'd2, 2'd0));
    pending_reqs.push_back(make_req(REQ_ADD_READY, 4'd5, 3'd2, 2'd0));
    pending_reqs.push_back(make_req(REQ_REM_READY, 4'd4, 3'd5, 2'd2));
    pending_reqs.push_back(make_req(REQ_REM_READY, 4'd5, 3'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_REM_READY, 4'd3, 3'd0, 2'd1));
    pending_reqs.push_back(make_req(REQ_ADD_READY, 4'd0, 3'd1, 2'd0));
    pending_reqs.push_back(make_req(REQ_TICK, 4'd0, 3'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_REM_READY, 4'd0, 3'd0, 2'd3));
    pending_reqs.push_back(make_req(REQ_ADD_READY, 4'd1, 3'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_ADD_READY, 4'd1, 3'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_TICK, 4'd0, 3'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_TICK + 3'd1, 4'd15, 3'd7, 2'd3));
    pending_reqs.push_back(make_req(3'd7, 4'd1, 3'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_TICK, 4'd15, 3'd7, 2'd3));
    drain();

    for (int p = 0; p < 5; p++) begin
      write_idle_level(phase_levels[p]);
      calm = (p == 3);
      for (int n = 0; n < 350; n++) pending_reqs.push_back(random_req());
      drain();
    end

    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== priority_task_scheduler.f =====
rtl/pts_pkg.sv
rtl/pts_if.sv
rtl/priority_task_scheduler.sv
verif/priority_task_scheduler_tb.sv
